### src/bitmap_rank_sparse_store_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap rank sparse store
// Shared shorthand for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RANK_SPARSE_STORE_DEFINES_SVH
`define BITMAP_RANK_SPARSE_STORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BRS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Types, op codes and helpers shared by the sparse store modules.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int MAP_WORDS_DEF = 64;
    localparam int CODE_BITS_DEF = 32;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 12;
    localparam int CODE_W  = 32;
    localparam int SLOT_W  = 13;
    localparam int POP_W   = 7;

    // op codes
    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    // input word
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  edge_key;
        logic [CODE_W-1:0] payload_code;
    } t_in;

    // result word
    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] dense_slot;
        logic [CODE_W-1:0] stored_code;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic pop_en;
        logic slot_en;
        logic res_en;
        logic write_hit;
        logic mark;
        logic bump_start;
        logic bump_step;
        logic shift_start;
        logic shift_step;
        logic insert;
        logic clr_start;
        logic clr_step;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic in_map;
        logic hit;
        logic full;
        logic bump_none;
        logic idx_last;
        logic shift_none;
        logic shift_last;
    } t_dp_sts;

    // population count of a 64-bit word
    function automatic logic [POP_W-1:0] popcount64(input logic [63:0] v);
        logic [63:0]      a;
        logic [63:0]      b;
        logic [63:0]      c;
        logic [POP_W-1:0] s;
        a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
        b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
        c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + POP_W'(c[8*k +: 8]);
        end
        return s;
    endfunction

endpackage

### src/brs_ram.sv
// ----------------------------------------------------------------------------
// brs_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module brs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/brs_datapath.sv
// ----------------------------------------------------------------------------
// brs_datapath
// Presence/rank map RAM, packed code RAM, rank and slot arithmetic.
// ----------------------------------------------------------------------------
module brs_datapath #(
    parameter int MAP_WORDS = brs_pkg::MAP_WORDS_DEF,
    parameter int CODE_BITS = brs_pkg::CODE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  brs_pkg::t_in     i_cmd_in,
    input  brs_pkg::t_dp_cmd i_ctl,
    output brs_pkg::t_dp_sts o_sts,
    output brs_pkg::t_out    o_result
);

    localparam int SLOT_COUNT = MAP_WORDS * 64;
    localparam int WA = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SA = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int MW = 64 + CW;
    localparam logic [WA:0]   LAST_IDX = (WA + 1)'(MAP_WORDS - 1);
    localparam logic [CW:0]   SLOT_LIM = (CW + 1)'(SLOT_COUNT);
    localparam logic [CW-1:0] SLOT_MAX = CW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOT_COUNT);
    localparam int KW = brs_pkg::KEY_W;

    // latched item
    logic [brs_pkg::OP_W-1:0] r_op;
    logic                     r_in_map;
    logic [WA-1:0]            r_word;
    logic [5:0]               r_bitpos;
    logic [CODE_BITS-1:0]     r_code;

    // lookup state
    logic [63:0]               r_pword;
    logic [CW-1:0]             r_rank;
    logic [brs_pkg::POP_W-1:0] r_pop;
    logic                      r_hit;
    logic [CW-1:0]             r_slot;

    // sweep and occupancy
    logic [CW-1:0] r_count;
    logic [WA:0]   r_idx;
    logic [SA-1:0] r_sidx;

    // result
    logic                      r_res_present;
    logic [CW-1:0]             r_res_slot;
    logic [brs_pkg::CODE_W-1:0] r_res_code;

    // RAM ports
    logic           map_we;
    logic [WA-1:0]  map_waddr;
    logic [MW-1:0]  map_wdata;
    logic           map_re;
    logic [WA-1:0]  map_raddr;
    logic [MW-1:0]  map_rdata;
    logic [63:0]    map_rd_word;
    logic [CW-1:0]  map_rd_rank;

    logic                 code_we;
    logic [SA-1:0]        code_waddr;
    logic [CODE_BITS-1:0] code_wdata;
    logic                 code_re;
    logic [SA-1:0]        code_raddr;
    logic [CODE_BITS-1:0] code_rdata;

    logic [CW:0]   slot_sum;
    logic [CW-1:0] slot_calc;

    assign map_rd_word = map_rdata[63:0];
    assign map_rd_rank = map_rdata[MW-1:64];

    // slot = word rank + ones below the key, clamped; out-of-map keys take the entry count
    assign slot_sum = {1'b0, r_rank} + (CW + 1)'(r_pop);
    always_comb begin
        if (!r_in_map) begin
            slot_calc = r_count;
        end else if (slot_sum >= SLOT_LIM) begin
            slot_calc = SLOT_MAX;
        end else begin
            slot_calc = slot_sum[CW-1:0];
        end
    end

    // item latch and lookup registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op     <= i_cmd_in.op;
            r_in_map <= (32'(i_cmd_in.edge_key[KW-1:6]) < 32'(MAP_WORDS));
            r_word   <= WA'(i_cmd_in.edge_key[KW-1:6]);
            r_bitpos <= i_cmd_in.edge_key[5:0];
            r_code   <= CODE_BITS'(i_cmd_in.payload_code);
        end
        if (i_ctl.pop_en) begin
            r_pword <= map_rd_word;
            r_rank  <= map_rd_rank;
            r_hit   <= r_in_map & map_rd_word[r_bitpos];
            r_pop   <= brs_pkg::popcount64(map_rd_word &
                                           ~(64'hFFFF_FFFF_FFFF_FFFF << r_bitpos));
        end
        if (i_ctl.slot_en) begin
            r_slot <= slot_calc;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_res_present <= 1'b0;
            r_res_slot    <= '0;
            r_res_code    <= '0;
        end else if (i_ctl.res_en) begin
            r_res_present <= r_hit;
            r_res_slot    <= r_slot;
            r_res_code    <= r_hit ? brs_pkg::CODE_W'(code_rdata) : '0;
        end
    end

    // occupancy and sweep pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_ctl.clr_start) begin
                r_count <= '0;
            end else if (i_ctl.insert) begin
                r_count <= r_count + 1'b1;
            end
            if (i_ctl.clr_start) begin
                r_idx <= '0;
            end else if (i_ctl.bump_start) begin
                r_idx <= {1'b0, r_word} + 1'b1;
            end else if (i_ctl.clr_step || i_ctl.bump_step) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_start) begin
            r_sidx <= SA'(r_count - 1'b1);
        end else if (i_ctl.shift_step) begin
            r_sidx <= r_sidx - 1'b1;
        end
    end

    // map RAM ports
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_idx[WA-1:0];
        map_wdata = '0;
        if (i_ctl.clr_step) begin
            map_we = 1'b1;
        end else if (i_ctl.mark) begin
            map_we    = 1'b1;
            map_waddr = r_word;
            map_wdata = {r_rank, r_pword | (64'd1 << r_bitpos)};
        end else if (i_ctl.bump_step) begin
            map_we    = 1'b1;
            map_wdata = {map_rd_rank + 1'b1, map_rd_word};
        end
        map_re    = i_ctl.load | i_ctl.bump_start | i_ctl.bump_step;
        map_raddr = WA'(r_idx + 1'b1);
        if (i_ctl.load) begin
            map_raddr = WA'(i_cmd_in.edge_key[KW-1:6]);
        end else if (i_ctl.bump_start) begin
            map_raddr = WA'({1'b0, r_word} + 1'b1);
        end
    end

    // code RAM ports
    always_comb begin
        code_we    = 1'b0;
        code_waddr = SA'(r_slot);
        code_wdata = r_code;
        if (i_ctl.write_hit || i_ctl.insert) begin
            code_we = 1'b1;
        end else if (i_ctl.shift_step) begin
            code_we    = 1'b1;
            code_waddr = r_sidx + 1'b1;
            code_wdata = code_rdata;
        end
        code_re    = i_ctl.slot_en | i_ctl.shift_start | i_ctl.shift_step;
        code_raddr = r_sidx - 1'b1;
        if (i_ctl.slot_en) begin
            code_raddr = SA'(slot_calc);
        end else if (i_ctl.shift_start) begin
            code_raddr = SA'(r_count - 1'b1);
        end
    end

    brs_ram #(
        .WIDTH (MW),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    brs_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (code_waddr),
        .i_wdata (code_wdata),
        .i_re    (code_re),
        .i_raddr (code_raddr),
        .o_rdata (code_rdata)
    );

    // status
    assign o_sts.op         = r_op;
    assign o_sts.in_map     = r_in_map;
    assign o_sts.hit        = r_hit;
    assign o_sts.full       = (r_count == FULL_CNT);
    assign o_sts.bump_none  = ({1'b0, r_word} == LAST_IDX);
    assign o_sts.idx_last   = (r_idx == LAST_IDX);
    assign o_sts.shift_none = (r_count == r_slot);
    assign o_sts.shift_last = (r_sidx == SA'(r_slot));

    assign o_result.present     = r_res_present;
    assign o_result.dense_slot  = brs_pkg::SLOT_W'(r_res_slot);
    assign o_result.stored_code = r_res_code;

endmodule

### src/brs_ctrl.sv
// ----------------------------------------------------------------------------
// brs_ctrl
// Sequencer: lookup, rank bump sweep, entry shift sweep and clear sweep.
// ----------------------------------------------------------------------------
`include "bitmap_rank_sparse_store_defines.svh"

module brs_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [brs_pkg::OP_W-1:0]       i_op,
    input  brs_pkg::t_dp_sts               i_sts,
    output brs_pkg::t_dp_cmd               o_cmd,
    output logic                           o_busy,
    output logic                           o_valid
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MAP,
        S_RANK,
        S_CODE,
        S_BUMP,
        S_SHIFT,
        S_INSERT
    } t_state;

    t_state r_state;
    logic   r_emit;
    logic   r_valid;
    logic   hit_set;
    logic   ins;

    assign hit_set = (i_sts.op == brs_pkg::OP_SET) && i_sts.in_map && i_sts.hit;
    assign ins     = (i_sts.op == brs_pkg::OP_SET) && i_sts.in_map && !i_sts.hit &&
                     !i_sts.full;

    // command decode
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.clr_start = (i_op == brs_pkg::OP_CLEAR);
                end
            end
            S_MAP: begin
                o_cmd.pop_en = 1'b1;
            end
            S_RANK: begin
                o_cmd.slot_en = 1'b1;
            end
            S_CODE: begin
                o_cmd.res_en = 1'b1;
                if (hit_set) begin
                    o_cmd.write_hit = 1'b1;
                end else if (ins) begin
                    o_cmd.mark        = 1'b1;
                    o_cmd.bump_start  = !i_sts.bump_none;
                    o_cmd.shift_start = i_sts.bump_none;
                end
            end
            S_BUMP: begin
                o_cmd.bump_step   = 1'b1;
                o_cmd.shift_start = i_sts.idx_last;
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_emit  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    if (i_sts.idx_last) begin
                        r_state <= S_IDLE;
                        r_valid <= r_emit;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        unique case (i_op) inside
                            brs_pkg::OP_QUERY, brs_pkg::OP_SET: begin
                                r_state <= S_MAP;
                            end
                            brs_pkg::OP_CLEAR: begin
                                r_state <= S_CLR;
                                r_emit  <= 1'b1;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MAP: begin
                    r_state <= S_RANK;
                end
                S_RANK: begin
                    r_state <= S_CODE;
                end
                S_CODE: begin
                    if (ins) begin
                        if (!i_sts.bump_none) begin
                            r_state <= S_BUMP;
                        end else if (i_sts.shift_none) begin
                            r_state <= S_INSERT;
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                S_BUMP: begin
                    if (i_sts.idx_last) begin
                        r_state <= i_sts.shift_none ? S_INSERT : S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (i_sts.shift_last) begin
                        r_state <= S_INSERT;
                    end
                end
                S_INSERT: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // checks
    `BRS_ASSERT_IMP(a_valid_in_idle, i_clk, i_rst_n, o_valid, r_state == S_IDLE,
                    "result strobe outside idle")
    `BRS_ASSERT_NXT(a_lookup_busy, i_clk, i_rst_n,
                    i_start && !o_busy && (i_op == brs_pkg::OP_QUERY ||
                    i_op == brs_pkg::OP_SET), o_busy && !o_valid,
                    "lookup did not start")
    `BRS_ASSERT_IMP(a_insert_room, i_clk, i_rst_n, r_state == S_INSERT, !i_sts.full,
                    "insert into a full store")
    `BRS_ASSERT_IMP(a_shift_absent, i_clk, i_rst_n, r_state == S_SHIFT,
                    i_sts.in_map && !i_sts.hit, "shift for a present key")

endmodule

### src/bitmap_rank_sparse_store.sv
// ----------------------------------------------------------------------------
// bitmap_rank_sparse_store
// Sparse keyed store: presence bitmap with per-word ranks, packed codes.
// ----------------------------------------------------------------------------
// Query, overwrite, out-of-map: map, rank and code states, then the result; an unused op
// gives its result from idle. Insert: the lookup states, then the rank bump over the map
// RAM, the one-entry-a-cycle shift in the code RAM and the insert state.
// Clear: a sweep over every map word. A new word can be accepted while the result strobe is high.
// Reset: a clearing pass over the map RAM runs with busy high, no result.
// Results are a one-cycle o_valid strobe; the receiver cannot stall.
module bitmap_rank_sparse_store #(
    parameter int MAP_WORDS = brs_pkg::MAP_WORDS_DEF,
    parameter int CODE_BITS = brs_pkg::CODE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  brs_pkg::t_in  i_cmd,
    output logic          busy,
    output logic          o_valid,
    output brs_pkg::t_out o_result
);

    brs_pkg::t_dp_cmd ctl;
    brs_pkg::t_dp_sts sts;

    brs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_cmd.op),
        .i_sts   (sts),
        .o_cmd   (ctl),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    brs_datapath #(
        .MAP_WORDS (MAP_WORDS),
        .CODE_BITS (CODE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_in (i_cmd),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule
